[src/srle_pkg.sv]
// ---------------------------------------------------------------------------
// srle_pkg
// Shared types and constants for the snapshot run-length decoder.
// ---------------------------------------------------------------------------
package srle_pkg;

	localparam logic [7:0] ESC_BYTE  = 8'hED;
	localparam logic [7:0] ZERO_BYTE = 8'h00;

	// bytes held back to spot the end marker, and the window seen per step
	localparam int LA_DEPTH = 3;
	localparam int QDEPTH   = LA_DEPTH + 1;

	// most results one input beat can release
	localparam int MAX_RES = 6;
	localparam int CNT_W   = $clog2(MAX_RES + 1);

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_COUNT  = 2'd1,
		PH_VALUE  = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       block_last;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] run_value;
		logic [7:0] run_length;
		logic       block_end;
		logic       truncated;
	} out_beat_t;

	typedef struct packed {
		logic [LA_DEPTH-1:0][7:0] la;
		logic [1:0]               fill;
		logic                     held;
		phase_t                   phase;
		logic [7:0]               pend;
		logic                     stopped;
	} state_t;

	typedef struct packed {
		out_beat_t [MAX_RES-1:0] run;
		logic [CNT_W-1:0]        cnt;
	} result_set_t;

endpackage

[src/srle_step.sv]
// ---------------------------------------------------------------------------
// srle_step
// One decode step: held bytes plus the new byte in, next state and the
// results released by this beat out.
// ---------------------------------------------------------------------------
module srle_step
	import srle_pkg::*;
(
	input  state_t      cur,
	input  in_beat_t    beat,
	output state_t      nxt,
	output result_set_t res
);

	logic [QDEPTH-1:0][7:0] q;
	logic [2:0]             n;
	logic [CNT_W-1:0]       k;
	phase_t                 ph;
	logic [7:0]             pend;
	logic                   held;
	logic                   stop;
	logic                   done;
	logic                   brk;
	logic                   take;
	logic                   marker;
	logic                   trunc;
	logic [1:0]             brk_i;
	logic [2:0]             src;

	function automatic out_beat_t make_run(logic [7:0] value, logic [7:0] count);
		out_beat_t r;
		r.run_value  = value;
		r.run_length = count;
		r.block_end  = 1'b0;
		r.truncated  = 1'b0;
		return r;
	endfunction

	always_comb begin
		// window: held bytes, oldest first, then the new byte
		q = '0;
		for (int j = 0; j < LA_DEPTH; j++) begin
			if (2'(j) < cur.fill) begin
				q[j] = cur.la[j];
			end
		end
		q[cur.fill] = beat.data_byte;
		n = {1'b0, cur.fill} + 3'd1;

		marker = (q[0] == ZERO_BYTE) && (q[1] == ESC_BYTE) &&
			(q[2] == ESC_BYTE) && (q[3] == ZERO_BYTE);

		ph    = cur.phase;
		pend  = cur.pend;
		held  = cur.held;
		stop  = cur.stopped;
		done  = cur.stopped;
		brk   = 1'b0;
		brk_i = '0;
		take  = 1'b0;
		k     = '0;
		res   = '0;

		for (int i = 0; i < QDEPTH; i++) begin
			take = 1'b0;
			if (!done && (3'(i) < n)) begin
				unique case (ph)
					PH_COUNT: begin
						pend = q[i];
						ph   = PH_VALUE;
					end
					PH_VALUE: begin
						if (pend != '0) begin
							res.run[k] = make_run(q[i], pend);
							k = k + 1'b1;
						end
						pend = '0;
						ph   = PH_NORMAL;
					end
					default: begin
						ph = PH_NORMAL;
						if ((i == 0) && (n == 3'(QDEPTH))) begin
							// full window: check for end marker first
							if (marker) begin
								stop = 1'b1;
								held = 1'b0;
								done = 1'b1;
							end else begin
								take = 1'b1;
							end
						end else if (!beat.block_last) begin
							// not enough lookahead yet, hold the rest
							done  = 1'b1;
							brk   = 1'b1;
							brk_i = 2'(i);
						end else begin
							take = 1'b1;
						end
					end
				endcase

				if (take) begin
					if (held) begin
						held = 1'b0;
						if (q[i] == ESC_BYTE) begin
							ph = PH_COUNT;
						end else begin
							res.run[k] = make_run(ESC_BYTE, 8'd1);
							k = k + 1'b1;
							res.run[k] = make_run(q[i], 8'd1);
							k = k + 1'b1;
						end
					end else if (q[i] == ESC_BYTE) begin
						held = 1'b1;
					end else begin
						res.run[k] = make_run(q[i], 8'd1);
						k = k + 1'b1;
					end
				end
			end
		end

		trunc = !stop && ((ph == PH_COUNT) || (ph == PH_VALUE));
		nxt   = '0;
		src   = '0;

		if (beat.block_last) begin
			// end of block: empty end result if nothing else, then clear all
			if (k == '0) begin
				res.run[0] = make_run(ZERO_BYTE, 8'd0);
				k = CNT_W'(1);
			end
			res.run[k - 1'b1].block_end = 1'b1;
			res.run[k - 1'b1].truncated = trunc;
		end else begin
			nxt.phase   = ph;
			nxt.pend    = pend;
			nxt.held    = held;
			nxt.stopped = stop;
			if (brk) begin
				nxt.fill = 2'(n - {1'b0, brk_i});
				for (int j = 0; j < LA_DEPTH; j++) begin
					src = {1'b0, brk_i} + 3'(j);
					if (src < n) begin
						nxt.la[j] = q[src[1:0]];
					end
				end
			end
		end

		res.cnt = k;
	end

endmodule

[src/srle_outbuf.sv]
// ---------------------------------------------------------------------------
// srle_outbuf
// Result register bank: loads all results of one step, drains one per beat.
// ---------------------------------------------------------------------------
module srle_outbuf
	import srle_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  result_set_t res,
	output logic        free,
	output logic        run_valid,
	input  logic        run_ready,
	output out_beat_t   run_beat
);

	out_beat_t [MAX_RES-1:0] slot_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        idx_q;
	logic                    pop;
	logic                    pop_last;

	assign run_valid = (idx_q != cnt_q);
	assign pop       = run_valid && run_ready;
	assign pop_last  = pop && ((idx_q + 1'b1) == cnt_q);
	assign free      = !run_valid || pop_last;
	assign run_beat  = slot_q[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (load) begin
			cnt_q <= res.cnt;
			idx_q <= '0;
		end else if (pop_last) begin
			cnt_q <= '0;
			idx_q <= '0;
		end else if (pop) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q <= res.run;
		end
	end

endmodule

[src/snapshot_rle_decoder.sv]
// ---------------------------------------------------------------------------
// snapshot_rle_decoder
// Streaming run-length decoder for one compressed snapshot memory block.
// ---------------------------------------------------------------------------
// Usage:
//   code channel: one compressed byte per beat, block_last on the final one.
//   run channel : (run_value, run_length) beats; block_end marks the block's
//                 last result, truncated flags an escape cut off at the end.
//   ED ED n v gives one run (v, n); n = 0 gives nothing. Decoding stops at
//   the 00 ED ED 00 marker; the rest of the block up to block_last is eaten.
// Path: a byte's result shows after the input and result bank registers;
//   bytes may be held back up to three beats to look for the end marker.
// Throughput: one byte per cycle while each byte yields at most one result
//   and run_ready holds. A step yielding more than one result holds the code
//   channel while the result bank drains them one beat per cycle.
// Reset: clears decode state and both valid flags; the next byte starts a
//   fresh block. Every block_last beat also returns the state to reset.
// Stall: one byte is held in the input register while the result bank is
//   busy; code_ready drops only when that register is full and the bank
//   cannot take the next step's results.
// ---------------------------------------------------------------------------
module snapshot_rle_decoder
	import srle_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      code_valid,
	output logic      code_ready,
	input  in_beat_t  code_beat,
	output logic      run_valid,
	input  logic      run_ready,
	output out_beat_t run_beat
);

	in_beat_t    beat_s1;
	logic        valid_s1;
	state_t      state_q;
	state_t      state_nxt;
	result_set_t res;
	logic        free;
	logic        fire;

	// step runs once the result bank can take all of its results
	assign fire       = valid_s1 && free;
	assign code_ready = !valid_s1 || fire;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (code_ready) begin
			valid_s1 <= code_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (code_ready && code_valid) begin
			beat_s1 <= code_beat;
		end
	end

	// decode state: lookahead window, escape progress, stop flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	srle_step u_step (
		.cur  (state_q),
		.beat (beat_s1),
		.nxt  (state_nxt),
		.res  (res)
	);

	srle_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.res       (res),
		.free      (free),
		.run_valid (run_valid),
		.run_ready (run_ready),
		.run_beat  (run_beat)
	);

	// a block's last byte always releases at least the end result
	a_end_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		fire && beat_s1.block_last |-> res.cnt != '0)
		else $error("block end released no result");

	// state is back at reset after the block's last byte
	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && beat_s1.block_last |=> state_q == '0)
		else $error("state not cleared after block end");

	// held bytes only exist in the normal phase of a running block
	a_fill_normal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.fill != '0 |-> state_q.phase == PH_NORMAL && !state_q.stopped)
		else $error("lookahead held outside normal phase");

	// a single held escape never coexists with count or value phases
	a_held_normal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.held |-> state_q.phase == PH_NORMAL && !state_q.stopped)
		else $error("held escape outside normal phase");

	// step never releases more results than the bank holds
	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> res.cnt <= CNT_W'(MAX_RES))
		else $error("result count overflow");

endmodule
